@@ src/iedc_pkg.sv @@
// Shared types and codes for the infix digit expression evaluator.
`default_nettype none

package iedc_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_SYNTAX = 2'd2;

    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_MUL  = 2'd1;
    localparam logic [1:0] MUL_DIV  = 2'd2;

    localparam logic ADD_PLUS  = 1'b0;
    localparam logic ADD_MINUS = 1'b1;

    localparam logic [2:0] KIND_SKIP  = 3'd0;
    localparam logic [2:0] KIND_DIGIT = 3'd1;
    localparam logic [2:0] KIND_MUL   = 3'd2;
    localparam logic [2:0] KIND_ADD   = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       is_last;
        logic [2:0] kind;
        logic [3:0] arg;
    } token_t;

endpackage

`default_nettype wire

@@ src/infix_digit_expression_evaluator_core.sv @@
// Top level of the infix digit expression evaluator.
`default_nettype none

// Characters enter through a push/full queue port and are classified at once;
// inner spaces are dropped there and every other character is queued in a
// QUEUE_DEPTH-entry token queue. The execution unit takes one token a cycle
// while idle, a last one only with the output register free. A digit after
// '/' runs a bit-serial restoring divider (load, 32 shift-subtract steps,
// finish) that sets the worst-case rate. The result of the character marked
// last is held in a one-entry output register read through empty/pop; value
// is 0 whenever status reports divide by zero (1) or syntax error (2).
module infix_digit_expression_evaluator_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         char_code,
    input  wire logic               is_last,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      value,
    output logic [1:0]              status
);
    import iedc_pkg::*;

    token_t in_tok;
    token_t q_tok;
    logic   in_push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    iedc_front u_front
    (
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .is_last   (is_last),
        .tok_push  (in_push),
        .tok       (in_tok),
        .q_full    (q_full)
    );

    iedc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_push),
        .wr_data (in_tok),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_tok),
        .q_valid (q_valid)
    );

    iedc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (q_tok),
        .tok_valid (q_valid),
        .tok_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ src/iedc_front.sv @@
// Front end: accepts characters, classifies them and drops inner spaces.
`default_nettype none

module iedc_front
(
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      char_code,
    input  wire logic            is_last,
    output logic                 tok_push,
    output iedc_pkg::token_t     tok,
    input  wire logic            q_full
);
    import iedc_pkg::*;

    logic [3:0] digit_off;

    assign digit_off = 4'(char_code - CH_ZERO);
    assign full      = q_full;

    always_comb
    begin
        tok.is_last = is_last;
        tok.arg     = 4'd0;
        if (char_code == CH_SPACE)
        begin
            tok.kind = KIND_SKIP;
        end
        else if (char_code >= CH_ZERO && char_code <= CH_NINE)
        begin
            tok.kind = KIND_DIGIT;
            tok.arg  = digit_off;
        end
        else if (char_code == CH_STAR || char_code == CH_SLASH)
        begin
            tok.kind = KIND_MUL;
            tok.arg  = {2'b00, (char_code == CH_STAR) ? MUL_MUL : MUL_DIV};
        end
        else if (char_code == CH_PLUS || char_code == CH_MINUS)
        begin
            tok.kind = KIND_ADD;
            tok.arg  = {3'b000, (char_code == CH_MINUS) ? ADD_MINUS : ADD_PLUS};
        end
        else
        begin
            tok.kind = KIND_BAD;
        end
    end

    assign tok_push = push && !q_full && (tok.kind != KIND_SKIP || is_last);

endmodule

`default_nettype wire

@@ src/iedc_fifo.sv @@
// Short token queue between the front end and the execution unit.
`default_nettype none

module iedc_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire iedc_pkg::token_t wr_data,
    output logic                  q_full,
    input  wire logic             rd_en,
    output iedc_pkg::token_t      rd_data,
    output logic                  q_valid
);
    import iedc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    token_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/iedc_back.sv @@
// Execution unit: evaluates tokens, runs the serial divider, holds the result.
`default_nettype none

module iedc_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire iedc_pkg::token_t tok,
    input  wire logic             tok_valid,
    output logic                  tok_pop,
    output logic                  empty,
    input  wire logic             pop,
    output logic signed [31:0]    value,
    output logic [1:0]            status
);
    import iedc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] term_reg, term_next;
    logic        add_reg, add_next;
    logic [1:0]  mul_reg, mul_next;
    logic        exp_reg, exp_next;
    logic [1:0]  err_reg, err_next;
    logic        last_pend_reg, last_pend_next;
    logic        neg_reg, neg_next;
    logic [3:0]  dvs_reg, dvs_next;
    logic [31:0] q_reg, q_next;
    logic [3:0]  rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg, out_value_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic        out_free;
    logic        take_tok;
    logic        fin_fire;
    logic        start_div;
    logic        commit;
    logic        do_close;
    logic [31:0] t_sum, t_term, fold;
    logic        t_add, t_exp;
    logic [1:0]  t_mul, t_err, c_err;
    logic [4:0]  rem_sh;
    logic        ge;

    assign out_free = !out_valid_reg || pop;
    assign take_tok = (state_reg == S_IDLE) && tok_valid && (!tok.is_last || out_free);
    assign fin_fire = (state_reg == S_FIN) && (!last_pend_reg || out_free);
    assign tok_pop  = take_tok;
    assign empty    = !out_valid_reg;
    assign value    = out_value_reg;
    assign status   = out_status_reg;
    assign rem_sh   = {rem_reg, q_reg[31]};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        t_sum     = sum_reg;
        t_term    = term_reg;
        t_add     = add_reg;
        t_mul     = mul_reg;
        t_exp     = exp_reg;
        t_err     = err_reg;
        start_div = 1'b0;
        if (take_tok && err_reg == ST_OK)
        begin
            unique case (tok.kind)
                KIND_DIGIT:
                begin
                    if (exp_reg == 1'b0)
                    begin
                        t_err = ST_SYNTAX;
                    end
                    else
                    begin
                        if (mul_reg == MUL_MUL)
                        begin
                            t_term = term_reg * {28'd0, tok.arg};
                        end
                        else if (mul_reg == MUL_DIV)
                        begin
                            if (tok.arg == 4'd0)
                            begin
                                t_err  = ST_DIV0;
                                t_term = 32'd0;
                            end
                            else
                            begin
                                start_div = 1'b1;
                            end
                        end
                        else
                        begin
                            t_term = {28'd0, tok.arg};
                        end
                        t_mul = MUL_NONE;
                        t_exp = 1'b0;
                    end
                end
                KIND_MUL:
                begin
                    if (exp_reg)
                    begin
                        t_err = ST_SYNTAX;
                    end
                    else
                    begin
                        t_mul = tok.arg[1:0];
                        t_exp = 1'b1;
                    end
                end
                KIND_ADD:
                begin
                    if (exp_reg)
                    begin
                        t_err = ST_SYNTAX;
                    end
                    else
                    begin
                        t_sum  = add_reg ? sum_reg - term_reg : sum_reg + term_reg;
                        t_term = 32'd0;
                        t_add  = tok.arg[0];
                        t_mul  = MUL_NONE;
                        t_exp  = 1'b1;
                    end
                end
                KIND_BAD:
                begin
                    t_err = ST_SYNTAX;
                end
                default:
                begin
                end
            endcase
        end
        if (fin_fire)
        begin
            t_term = neg_reg ? 32'd0 - q_reg : q_reg;
        end
    end

    assign commit   = take_tok || fin_fire;
    assign do_close = (take_tok && tok.is_last && !start_div) || (fin_fire && last_pend_reg);
    assign fold     = t_add ? t_sum - t_term : t_sum + t_term;
    assign c_err    = (t_err == ST_OK && t_exp) ? ST_SYNTAX : t_err;

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        term_next       = term_reg;
        add_next        = add_reg;
        mul_next        = mul_reg;
        exp_next        = exp_reg;
        err_next        = err_reg;
        last_pend_next  = last_pend_reg;
        neg_next        = neg_reg;
        dvs_next        = dvs_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start_div)
                begin
                    state_next     = S_DIV;
                    last_pend_next = tok.is_last;
                    neg_next       = term_reg[31];
                    q_next         = term_reg[31] ? 32'd0 - term_reg : term_reg;
                    rem_next       = 4'd0;
                    cnt_next       = 5'd0;
                    dvs_next       = tok.arg;
                end
            end
            S_DIV:
            begin
                rem_next = ge ? 4'(rem_sh - {1'b0, dvs_reg}) : rem_sh[3:0];
                q_next   = {q_reg[30:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            if (do_close)
            begin
                out_valid_next  = 1'b1;
                out_status_next = c_err;
                out_value_next  = (c_err == ST_OK) ? fold : 32'd0;
                sum_next        = 32'd0;
                term_next       = 32'd0;
                add_next        = ADD_PLUS;
                mul_next        = MUL_NONE;
                exp_next        = 1'b1;
                err_next        = ST_OK;
            end
            else
            begin
                sum_next  = t_sum;
                term_next = t_term;
                add_next  = t_add;
                mul_next  = t_mul;
                exp_next  = t_exp;
                err_next  = t_err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        neg_reg        <= neg_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= 32'd0;
            term_reg      <= 32'd0;
            add_reg       <= ADD_PLUS;
            mul_reg       <= MUL_NONE;
            exp_reg       <= 1'b1;
            err_reg       <= ST_OK;
            last_pend_reg <= 1'b0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            add_reg       <= add_next;
            mul_reg       <= mul_next;
            exp_reg       <= exp_next;
            err_reg       <= err_next;
            last_pend_reg <= last_pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/iedc_checker.sv @@
// Port-level assertions for the evaluator core and their bind.
`default_nettype none

module iedc_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         empty,
    input  wire logic         pop,
    input  wire logic [31:0]  value,
    input  wire logic [1:0]   status
);
    import iedc_pkg::*;

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_OK || status == ST_DIV0 || status == ST_SYNTAX))
        else $error("illegal status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (value == 32'd0))
        else $error("nonzero value with error status");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value) && $stable(status)))
        else $error("waiting result changed before transfer");

endmodule

bind infix_digit_expression_evaluator_core iedc_checker u_iedc_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .value  (value),
    .status (status)
);

`default_nettype wire
